// ===== rtl/csds_pkg.sv =====
// shared types and constants for the counter sample delta scaler
package csds_pkg;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_WARMUP           = 3'd1,
    ST_NOT_RUNNING      = 3'd2,
    ST_CLOCK_REGRESSION = 3'd3,
    ST_COUNTER_RESET    = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] count;
    logic [63:0] enabled;
    logic [63:0] running;
    logic [63:0] stamp;
  } sample_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/csds_muldiv.sv =====
// iterative floor(a*b/d) with saturation, one quotient bit per cycle
module csds_muldiv import csds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] d_i,
  output div_ctl_t    ctl_o,
  output logic [63:0] quot_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  part_q;
  logic [127:0] prod_q;
  logic [63:0] a_q, b_q, d_q, rem_q, quot_q;
  logic [5:0]  bit_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;
  logic [64:0] rem_sh;
  logic        take;

  // one 32x32 partial product a cycle
  always_comb begin
    unique case (part_q)
      2'd0: begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
      2'd1: begin mul_a = a_q[31:0];  mul_b = b_q[63:32]; end
      2'd2: begin mul_a = a_q[63:32]; mul_b = b_q[31:0];  end
      default: begin mul_a = a_q[63:32]; mul_b = b_q[63:32]; end
    endcase
    pp = 64'(mul_a) * 64'(mul_b);
  end

  assign rem_sh = {rem_q, prod_q[7'(bit_q)]};
  assign take   = rem_sh >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_MUL;
      S_MUL:  if (part_q == 2'd3) state_d = S_DIV;
      S_DIV:  if (prod_q[127:64] >= d_q || d_q == '0 || bit_q == '0) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      part_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        part_q <= '0;
        bit_q  <= 6'd63;
      end else if (state_q == S_MUL) begin
        part_q <= part_q + 2'd1;
      end else if (state_q == S_DIV) begin
        bit_q <= bit_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        a_q    <= a_i;
        b_q    <= b_i;
        d_q    <= d_i;
        prod_q <= '0;
        rem_q  <= '0;
        quot_q <= '0;
      end
      S_MUL: begin
        unique case (part_q)
          2'd0: prod_q <= prod_q + {64'd0, pp};
          2'd1, 2'd2: prod_q <= prod_q + {32'd0, pp, 32'd0};
          default: begin
            prod_q <= prod_q + {pp, 64'd0};
            rem_q  <= prod_q[127:64] + pp;
          end
        endcase
      end
      S_DIV: begin
        if (prod_q[127:64] >= d_q || d_q == '0) begin
          quot_q <= '1;
        end else begin
          rem_q  <= take ? 64'(rem_sh - {1'b0, d_q}) : rem_sh[63:0];
          quot_q <= {quot_q[62:0], take};
        end
      end
      default: ;
    endcase
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = state_q != S_IDLE;
  assign ctl_o.done  = state_q == S_DONE;
  assign quot_o      = quot_q;

endmodule

// ===== rtl/counter_sample_delta_scaler.sv =====
// top level: per-slot sample memory, sequencer and shared divider
// each item passes through memory read and evaluation, then takes no quotient, two or
//   three in the shared divider, then goes into the output register; a saturated
//   quotient leaves the divider early
// items are taken one at a time; the next item is taken once the
//   result is in the output register, which must be free before it is loaded
// reset: asynchronous, active low; clears seen bits and all control state
module counter_sample_delta_scaler import csds_pkg::*; #(
  parameter int EVENT_SLOTS     = 32,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [4:0]               event_slot_i,
  input  logic [63:0]              raw_count_i,
  input  logic [63:0]              time_enabled_i,
  input  logic [63:0]              time_running_i,
  input  logic [63:0]              sample_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [63:0]              interval_time_o,
  output logic                     deltas_ok_o,
  output logic [63:0]              delta_count_o,
  output logic [63:0]              delta_enabled_o,
  output logic [63:0]              delta_running_o,
  output logic                     scale_ok_o,
  output logic [63:0]              scaled_count_o,
  output logic [63:0]              delta_scaled_count_o,
  output logic [RATIO_FRAC_BITS:0] run_ratio_o
);

  localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_DIV1  = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_DIV3  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // sample memory, read into a register
  sample_t mem [EVENT_SLOTS];
  sample_t rd_q;
  logic [EVENT_SLOTS-1:0] seen_q;

  // current item
  sample_t     cur_q;
  logic        seen_cur_q;

  // result fields being built
  logic [2:0]  st_q;
  logic [63:0] ivl_q, dc_q, de_q, dr_q, sc_q, dsc_q, rat_q;
  logic        dv_q, sv_q, abs_q, dsc_en_q;

  // output register
  logic        ovalid_q;

  // divider
  logic        dv_start;
  logic [63:0] dv_a, dv_b, dv_d, div_quot;
  div_ctl_t    dv_ctl;

  logic        accept, out_free, in_rng;
  logic [AW-1:0] addr;
  logic        iv_ok, fwd_ok, drun_ok, dsc_go;
  logic [63:0] one_ratio;

  assign one_ratio = 64'd1 << RATIO_FRAC_BITS;
  assign in_rng    = 32'(event_slot_i) < 32'(EVENT_SLOTS);
  assign addr      = AW'(event_slot_i);
  assign out_free  = !ovalid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;
  assign accept    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[addr];
      if (in_rng) begin
        mem[addr] <= '{count: raw_count_i, enabled: time_enabled_i,
                       running: time_running_i, stamp: sample_time_i};
      end
    end
  end

  // evaluation of the comparisons once the previous sample is out
  assign iv_ok   = seen_cur_q && cur_q.stamp > rd_q.stamp;
  assign fwd_ok  = cur_q.count >= rd_q.count && cur_q.enabled >= rd_q.enabled
                   && cur_q.running >= rd_q.running;
  assign drun_ok = (cur_q.running != rd_q.running)
                   && (cur_q.enabled - rd_q.enabled >= cur_q.running - rd_q.running);
  // delta scaling needed for the item under evaluation
  assign dsc_go  = iv_ok && fwd_ok && drun_ok;

  // divider operand select per phase
  always_comb begin
    dv_start = 1'b0;
    dv_a = cur_q.running;
    dv_b = one_ratio;
    dv_d = cur_q.enabled;
    unique case (state_q)
      S_DIV1: begin
        dv_start = 1'b1;
        if (dsc_en_q) begin
          dv_a = dc_q; dv_b = de_q; dv_d = dr_q;
        end else begin
          dv_a = cur_q.count; dv_b = cur_q.enabled; dv_d = cur_q.running;
        end
      end
      S_DIV2: begin
        dv_start = 1'b1;
        if (dsc_en_q) begin
          dv_a = dr_q; dv_b = one_ratio; dv_d = de_q;
        end
      end
      S_DIV3: begin
        dv_start = 1'b1;
        dv_a = cur_q.count; dv_b = cur_q.enabled; dv_d = cur_q.running;
      end
      default: ;
    endcase
  end

  csds_muldiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start && !dv_ctl.busy),
    .a_i    (dv_a),
    .b_i    (dv_b),
    .d_i    (dv_d),
    .ctl_o  (dv_ctl),
    .quot_o (div_quot)
  );

  // sequencer: div1 = scaled (or delta scaled), div2 = ratio, div3 = scaled
  // when the delta path took div1
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = S_EVAL;
      S_EVAL: state_d = (abs_q || dsc_go) ? S_DIV1 : S_OUT;
      S_DIV1: if (dv_ctl.done) state_d = S_DIV2;
      S_DIV2: if (dv_ctl.done) state_d = (dsc_en_q && abs_q) ? S_DIV3 : S_OUT;
      S_DIV3: if (dv_ctl.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      seen_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_rng) seen_q[addr] <= 1'b1;
      if (state_q == S_OUT && out_free) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (accept) begin
        cur_q      <= '{count: raw_count_i, enabled: time_enabled_i,
                        running: time_running_i, stamp: sample_time_i};
        seen_cur_q <= in_rng && seen_q[addr];
      end
      S_READ: begin
        abs_q <= cur_q.running != '0 && cur_q.enabled >= cur_q.running;
      end
      S_EVAL: begin
        ivl_q <= iv_ok ? cur_q.stamp - rd_q.stamp : '0;
        sc_q  <= '0;
        dsc_q <= '0;
        rat_q <= '0;
        sv_q  <= abs_q;
        dv_q  <= 1'b0;
        dc_q  <= '0;
        de_q  <= '0;
        dr_q  <= '0;
        dsc_en_q <= 1'b0;
        st_q  <= seen_cur_q ? ST_OK : ST_WARMUP;
        if (iv_ok && fwd_ok) begin
          dv_q <= 1'b1;
          dc_q <= cur_q.count - rd_q.count;
          de_q <= cur_q.enabled - rd_q.enabled;
          dr_q <= cur_q.running - rd_q.running;
          if (drun_ok) begin
            dsc_en_q <= 1'b1;
            sv_q     <= 1'b1;
          end else begin
            sv_q <= 1'b0;
            st_q <= ST_NOT_RUNNING;
          end
        end else if (seen_cur_q && !iv_ok) begin
          st_q <= ST_CLOCK_REGRESSION;
        end else if (seen_cur_q) begin
          st_q <= ST_COUNTER_RESET;
        end
      end
      S_DIV1: if (dv_ctl.done) begin
        if (dsc_en_q) dsc_q <= div_quot;
        else          sc_q  <= div_quot;
      end
      S_DIV2: if (dv_ctl.done) rat_q <= div_quot;
      S_DIV3: if (dv_ctl.done) sc_q <= div_quot;
      default: ;
    endcase
  end

  // output register, loaded as the sequencer leaves its output state
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      status_o             <= st_q;
      interval_time_o      <= ivl_q;
      deltas_ok_o          <= dv_q;
      delta_count_o        <= dc_q;
      delta_enabled_o      <= de_q;
      delta_running_o      <= dr_q;
      scale_ok_o           <= sv_q;
      scaled_count_o       <= sc_q;
      delta_scaled_count_o <= dsc_q;
      run_ratio_o          <= rat_q[RATIO_FRAC_BITS:0];
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// ===== rtl/csds_checker.sv =====
// port-level checks for the counter sample delta scaler
module csds_checker import csds_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        deltas_ok_o,
  input logic        scale_ok_o,
  input logic [63:0] delta_scaled_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_warm_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_WARMUP |-> !deltas_ok_o)
    else $error("deltas on warmup");

  a_dsc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(deltas_ok_o && scale_ok_o) |-> delta_scaled_count_o == '0)
    else $error("delta scaled count without deltas");

endmodule

bind counter_sample_delta_scaler csds_checker u_csds_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .status_o            (status_o),
  .deltas_ok_o         (deltas_ok_o),
  .scale_ok_o          (scale_ok_o),
  .delta_scaled_count_o(delta_scaled_count_o)
);

// ===== bench/tb_counter_sample_delta_scaler.sv =====
// testbench for the counter sample delta scaler: queued driver, monitor, scoreboard
module tb_counter_sample_delta_scaler;
  import csds_pkg::*;

  localparam int SLOTS = 32;
  localparam int FRAC  = 16;

  typedef struct {
    logic [4:0]  slot;
    logic [63:0] raw;
    logic [63:0] en;
    logic [63:0] run;
    logic [63:0] stamp;
  } sample_item_t;

  typedef struct {
    status_e     status;
    logic [63:0] interval;
    logic        dvalid;
    logic [63:0] dcount;
    logic [63:0] den;
    logic [63:0] drun;
    logic        svalid;
    logic [63:0] scaled;
    logic [63:0] dscaled;
    logic [FRAC:0] ratio;
  } scaled_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [4:0] event_slot_i = '0;
  logic [63:0] raw_count_i = '0, time_enabled_i = '0, time_running_i = '0, sample_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [63:0] interval_time_o, delta_count_o, delta_enabled_o, delta_running_o;
  logic deltas_ok_o, scale_ok_o;
  logic [63:0] scaled_count_o, delta_scaled_count_o;
  logic [FRAC:0] run_ratio_o;

  counter_sample_delta_scaler #(.EVENT_SLOTS(SLOTS), .RATIO_FRAC_BITS(FRAC)) dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state, one copy per slot
  logic [63:0] last_count [SLOTS];
  logic [63:0] last_en [SLOTS];
  logic [63:0] last_run [SLOTS];
  logic [63:0] last_stamp [SLOTS];
  logic        slot_seen [SLOTS];

  sample_item_t   pending_samples[$];
  scaled_result_t expected_results[$];
  int errors = 0;
  int accepted = 0, checked = 0, n_ok = 0, n_nr = 0;
  bit hold_input = 0;
  int long_stall = 0;

  // floor(a*b/d) saturated at 64 bits
  function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] q;
    prod = a * b;
    if (d == 0) return '1;
    q = prod / d;
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic scaled_result_t predict_sample(sample_item_t s);
    scaled_result_t r;
    logic seen, iv_ok;
    logic [63:0] pc, pe, pr, pt, rq;
    seen = slot_seen[s.slot];
    pc = seen ? last_count[s.slot] : 0;
    pe = seen ? last_en[s.slot] : 0;
    pr = seen ? last_run[s.slot] : 0;
    pt = seen ? last_stamp[s.slot] : 0;
    iv_ok = seen && (s.stamp > pt);
    r.status = seen ? ST_OK : ST_WARMUP;
    r.interval = iv_ok ? s.stamp - pt : 0;
    r.dvalid = 0; r.dcount = 0; r.den = 0; r.drun = 0;
    r.scaled = 0; r.dscaled = 0; rq = 0;
    r.svalid = (s.run > 0) && (s.en >= s.run);
    if (r.svalid) begin
      rq = scale_div(s.run, 64'd1 << FRAC, s.en);
      r.scaled = scale_div(s.raw, s.en, s.run);
    end
    if (iv_ok && s.raw >= pc && s.en >= pe && s.run >= pr) begin
      r.dvalid = 1;
      r.dcount = s.raw - pc;
      r.den = s.en - pe;
      r.drun = s.run - pr;
      if (r.drun > 0 && r.den >= r.drun) begin
        r.dscaled = scale_div(r.dcount, r.den, r.drun);
        rq = scale_div(r.drun, 64'd1 << FRAC, r.den);
        r.svalid = 1;
      end else begin
        r.svalid = 0;
        r.status = ST_NOT_RUNNING;
      end
    end else if (seen && !iv_ok) begin
      r.status = ST_CLOCK_REGRESSION;
    end else if (seen) begin
      r.status = ST_COUNTER_RESET;
    end
    r.ratio = rq[FRAC:0];
    last_count[s.slot] = s.raw;
    last_en[s.slot] = s.en;
    last_run[s.slot] = s.run;
    last_stamp[s.slot] = s.stamp;
    slot_seen[s.slot] = 1;
    return r;
  endfunction

  // driver: bursts and gaps, holds payload while stalled
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_sample(pending_samples.pop_front()));
        accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0 && !hold_input &&
                     !(in_valid_i && !in_stall_o && pending_samples.size() == 0)) begin
          event_slot_i   <= pending_samples[0].slot;
          raw_count_i    <= pending_samples[0].raw;
          time_enabled_i <= pending_samples[0].en;
          time_running_i <= pending_samples[0].run;
          sample_time_i  <= pending_samples[0].stamp;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i) begin
    scaled_result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          e = expected_results.pop_front();
          checked++;
          if (e.status == ST_OK) n_ok++;
          if (e.status == ST_NOT_RUNNING) n_nr++;
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++; end
          if (interval_time_o !== e.interval) begin
            $error("interval_time exp %0h got %0h", e.interval, interval_time_o); errors++; end
          if (deltas_ok_o !== e.dvalid) begin
            $error("deltas_ok exp %0b got %0b", e.dvalid, deltas_ok_o); errors++; end
          if (delta_count_o !== e.dcount) begin
            $error("delta_count exp %0h got %0h", e.dcount, delta_count_o); errors++; end
          if (delta_enabled_o !== e.den) begin
            $error("delta_enabled exp %0h got %0h", e.den, delta_enabled_o); errors++; end
          if (delta_running_o !== e.drun) begin
            $error("delta_running exp %0h got %0h", e.drun, delta_running_o); errors++; end
          if (scale_ok_o !== e.svalid) begin
            $error("scale_ok exp %0b got %0b", e.svalid, scale_ok_o); errors++; end
          if (scaled_count_o !== e.scaled) begin
            $error("scaled_count exp %0h got %0h", e.scaled, scaled_count_o); errors++; end
          if (delta_scaled_count_o !== e.dscaled) begin
            $error("delta_scaled_count exp %0h got %0h", e.dscaled, delta_scaled_count_o);
            errors++; end
          if (run_ratio_o !== e.ratio) begin
            $error("run_ratio exp %0h got %0h", e.ratio, run_ratio_o); errors++; end
        end
      end
      if (long_stall > 0) begin
        long_stall--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 9) < 3) && ((accepted / 50) % 2 == 1);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return '1;
      2: return $urandom_range(0, 3);
      3: return 64'h8000_0000_0000_0000;
      default: return rand64();
    endcase
  endfunction

  task automatic add_sample(logic [4:0] sl, logic [63:0] r, logic [63:0] e,
                            logic [63:0] ru, logic [63:0] t);
    sample_item_t s;
    s.slot = sl; s.raw = r; s.en = e; s.run = ru; s.stamp = t;
    pending_samples.push_back(s);
  endtask

  // random walk state per slot for well-formed sequences
  logic [63:0] walk_c [SLOTS], walk_e [SLOTS], walk_r [SLOTS], walk_t [SLOTS];

  initial begin
    logic [63:0] de, dr;
    int sl, k;
    for (int i = 0; i < SLOTS; i++) begin
      slot_seen[i] = 0;
      walk_c[i] = 0; walk_e[i] = 0; walk_r[i] = 0; walk_t[i] = 0;
    end
    // directed: warmup, ok, not running, clock regression, counter reset, saturation
    add_sample(0, 0, 0, 0, 0);
    add_sample(0, 100, 2000, 1000, 10);
    add_sample(0, 300, 4000, 1000, 20);
    add_sample(0, 400, 5000, 1000, 20);
    add_sample(0, 50, 6000, 2000, 30);
    add_sample(0, 60, 5000, 2000, 40);
    add_sample(1, '1, '1, 1, 5);
    add_sample(1, '1, '1, 2, '1);
    add_sample(31, '1, '1, '1, '1);
    add_sample(31, '1, '1, '1, 0);
    add_sample(2, 64'd1 << 40, 64'd1 << 50, 64'd1 << 50, 1);
    add_sample(2, 64'd1 << 41, 64'd3 << 50, 64'd3 << 49, 2);
    add_sample(3, 5, 10, 20, 1);
    add_sample(3, 6, 20, 30, 2);
    add_sample(4, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    add_sample(4, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int n = 0; n < 400; n++) begin
      k = $urandom_range(0, 9);
      sl = (k == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
      if (k < 7) begin
        // well-formed advance with random step sizes
        dr = (k == 6) ? 0 : ($urandom_range(0, 3) == 0 ? rand64() >> $urandom_range(1, 63)
                                                          : $urandom_range(1, 100000));
        de = dr + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 100000));
        walk_c[sl] += ($urandom_range(0, 4) == 0) ? rand64() >> $urandom_range(0, 63)
                                                   : $urandom_range(0, 1 << 20);
        walk_e[sl] += de; walk_r[sl] += dr;
        walk_t[sl] += $urandom_range(1, 1 << 24);
        add_sample(5'(sl), walk_c[sl], walk_e[sl], walk_r[sl], walk_t[sl]);
      end else begin
        walk_c[sl] = pick_edge(); walk_e[sl] = pick_edge();
        walk_r[sl] = pick_edge(); walk_t[sl] = pick_edge();
        add_sample(5'(sl), walk_c[sl], walk_e[sl], walk_r[sl], walk_t[sl]);
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // receiver holds off while the sender keeps offering
    wait (accepted >= 120);
    @(posedge clk_i);
    long_stall = 3000;
    // sender pauses until the pipeline drains
    wait (accepted >= 250);
    hold_input = 1;
    wait (expected_results.size() == 0);
    @(posedge clk_i);
    hold_input = 0;
    wait (pending_samples.size() == 0);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("checked %0d results over %0d samples: %0d ok, %0d not running",
             checked, accepted, n_ok, n_nr);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #9000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
